/* rtl/nrv_pkg.sv */
`timescale 1ns / 1ps
// Package for the record validator: record layout constants, status and
// register codes, and the control struct of the bit-serial CRC unit.
// No dependencies.
package nrv_pkg;

  // Record layout: magic, version, length, data area, CRC.
  localparam logic [31:0] REC_MAGIC = 32'h4D4E564D;
  localparam int MAGIC_BYTES = 4;
  localparam int VER_END     = 6;
  localparam int HDR_BYTES   = 8;
  localparam int CRC_BYTES   = 4;
  localparam int DATA_LIMIT  = 32;

  // Reflected CRC-32.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int CRC_CNT_W = 4;
  localparam logic [CRC_CNT_W-1:0] CRC_BITS = 4'd8;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_INVALID     = 2'd1,
    STAT_NOT_FOUND   = 2'd2,
    STAT_STORAGE_ERR = 2'd3
  } status_t;

  // Storage read outcome codes.
  localparam logic [1:0] RS_OK        = 2'd0;
  localparam logic [1:0] RS_NOT_FOUND = 2'd1;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH     = 1'b1;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [7:0] din;
  } crc_ctl_t;

endpackage

/* rtl/nrv_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the record validator: record bytes in,
// result items out. No dependencies.
interface nrv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rec_byte;
  logic       last;
  logic [1:0] read_status;

  modport source(output valid, rec_byte, last, read_status, input ready);
  modport sink(input valid, rec_byte, last, read_status, output ready);
endinterface

interface nrv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       quality_valid;
  logic       dirty;
  logic [7:0] data_byte;
  logic [4:0] data_index;
  logic       last_out;

  modport source(output valid, status, quality_valid, dirty, data_byte, data_index,
                 last_out, input ready);
  modport sink(input valid, status, quality_valid, dirty, data_byte, data_index,
               last_out, output ready);
endinterface

/* rtl/nrv_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nrv_ram #(
  parameter int W = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/nrv_crc_bits.sv */
`timescale 1ns / 1ps
// Bit-serial reflected CRC-32 unit: folds a loaded byte in bit by bit.
// Depends on nrv_pkg.
module nrv_crc_bits (
  input  logic              clk,
  input  logic              rst_n,
  input  nrv_pkg::crc_ctl_t ctl,
  output logic              rdy,
  output logic [31:0]       crc
);
  import nrv_pkg::*;

  logic [31:0]          crc_r, crc_nxt;
  logic [7:0]           sh_r, sh_nxt;
  logic [CRC_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 fb;
  logic [31:0]          crc_step;

  // One LSB-first bit of the byte enters per cycle.
  assign fb       = crc_r[0] ^ sh_r[0];
  assign crc_step = {1'b0, crc_r[31:1]} ^ (fb ? CRC_POLY : 32'h0);

  always_comb begin
    crc_nxt = crc_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (cnt_r != '0) begin
      crc_nxt = crc_step;
      sh_nxt  = {1'b0, sh_r[7:1]};
      cnt_nxt = cnt_r - 1'b1;
    end
    // A new byte may be loaded on the cycle that shifts in the final bit.
    if (ctl.load) begin
      sh_nxt  = ctl.din;
      cnt_nxt = CRC_BITS;
    end
    if (ctl.clear) begin
      crc_nxt = CRC_INIT;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt;
  end

  assign rdy = (cnt_r <= CRC_CNT_W'(1));
  assign crc = crc_r;

  a_load_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> cnt_r <= CRC_CNT_W'(1))
    else $error("CRC unit loaded while a byte is still being shifted");

endmodule

/* rtl/nvm_record_validator_unit.sv */
`timescale 1ns / 1ps
// Top level of the stored-record validator: byte collection, header checks,
// check sequencer and data emission. Depends on nrv_pkg, nrv_if, nrv_ram
// and nrv_crc_bits.
//
//   Channel  Direction  Transfer carries
//   in_if    sink       rec_byte, last, read_status
//   out_if   source     status, quality_valid, dirty, data_byte, data_index,
//                       last_out
//   cfg_*    write      register index and value, no handshake
//
// Version, length and in-use data bytes are loaded into the bit-serial CRC
// unit, which shifts one bit per cycle; the next byte waits for its last bit.
// A check state follows the final byte; a valid record then emits one data
// byte per cycle (block_length bytes), a failure a single result.
// Synchronous active-low reset clears the run state; the data buffer is not
// cleared. An output stall holds the emission; new bytes are taken while a
// failure result still waits in the output register.
module nvm_record_validator_unit #(
  parameter int MAX_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  nrv_in_if.sink                          in_if,
  nrv_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [nrv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nrv_pkg::CFG_DW-1:0]      cfg_wdata
);
  import nrv_pkg::*;

  localparam int TOTAL = HDR_BYTES + MAX_BYTES + CRC_BYTES;
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int AW    = $clog2(MAX_BYTES);

  typedef enum logic [3:0] {
    ST_COLLECT = 4'b0001,
    ST_CHECK   = 4'b0010,
    ST_EMIT    = 4'b0100,
    ST_FAIL    = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] exp_version_r;
  logic [5:0]  block_length_r;
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic        ovf_r, ovf_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [31:0] stored_crc_r, stored_crc_nxt;
  logic [1:0]  rs_r, rs_nxt;
  status_t     fail_status_r, fail_status_nxt;
  logic [5:0]  emit_idx_r, emit_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r, out_ok_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [4:0]  out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_ready, in_acc, out_free, len_ok, good, emit_last;
  logic [7:0]  data_off;
  logic [CW-1:0] crc_off;
  logic        ram_we, ram_re;
  logic [7:0]  ram_rdata;
  crc_ctl_t    crc_ctl;
  logic        crc_rdy;
  logic [31:0] crc_val;

  nrv_crc_bits u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .rdy   (crc_rdy),
    .crc   (crc_val)
  );

  nrv_ram #(.W(8), .DEPTH(MAX_BYTES)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(data_off)),
    .wdata (in_if.rec_byte),
    .re    (ram_re),
    .raddr (AW'(emit_idx_r)),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_COLLECT) && crc_rdy;
  assign in_acc    = in_if.valid && in_ready;
  assign out_free  = !out_valid_r || out_if.ready;
  assign data_off  = 8'(byte_count_r) - 8'(HDR_BYTES);
  assign crc_off   = byte_count_r - CW'(HDR_BYTES + MAX_BYTES);
  assign emit_last = ((emit_idx_r + 6'd1) == block_length_r);
  assign len_ok    = (block_length_r != 6'd0) && (int'(block_length_r) <= MAX_BYTES) &&
                     (int'(block_length_r) <= DATA_LIMIT);
  assign good      = len_ok && !ovf_r && (byte_count_r == CW'(TOTAL)) && hdr_ok_r &&
                     (stored_crc_r == ~crc_val);

  always_comb begin
    state_nxt       = state_r;
    byte_count_nxt  = byte_count_r;
    ovf_nxt         = ovf_r;
    hdr_ok_nxt      = hdr_ok_r;
    stored_crc_nxt  = stored_crc_r;
    rs_nxt          = rs_r;
    fail_status_nxt = fail_status_r;
    emit_idx_nxt    = emit_idx_r;
    out_valid_nxt   = out_valid_r;
    out_ok_nxt      = out_ok_r;
    out_status_nxt  = out_status_r;
    out_idx_nxt     = out_idx_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    crc_ctl         = '{clear: 1'b0, load: 1'b0, din: in_if.rec_byte};

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_COLLECT: begin
        if (in_acc) begin
          // A failed read on the final item drops its byte.
          if (!in_if.last || in_if.read_status == RS_OK) begin
            if (int'(byte_count_r) >= TOTAL) begin
              ovf_nxt = 1'b1;
            end else begin
              byte_count_nxt = byte_count_r + 1'b1;
              if (int'(byte_count_r) < MAGIC_BYTES) begin
                if (in_if.rec_byte != REC_MAGIC[{byte_count_r[1:0], 3'b000} +: 8]) begin
                  hdr_ok_nxt = 1'b0;
                end
              end else if (int'(byte_count_r) < VER_END) begin
                if (in_if.rec_byte != (byte_count_r[0] ? exp_version_r[15:8]
                                                       : exp_version_r[7:0])) begin
                  hdr_ok_nxt = 1'b0;
                end
                crc_ctl.load = 1'b1;
              end else if (int'(byte_count_r) < HDR_BYTES) begin
                if (in_if.rec_byte != (byte_count_r[0] ? 8'h00
                                                       : {2'b00, block_length_r})) begin
                  hdr_ok_nxt = 1'b0;
                end
                crc_ctl.load = 1'b1;
              end else if (int'(byte_count_r) < HDR_BYTES + MAX_BYTES) begin
                ram_we = 1'b1;
                if (data_off < {2'b00, block_length_r}) begin
                  crc_ctl.load = 1'b1;
                end
              end else begin
                stored_crc_nxt[{crc_off[1:0], 3'b000} +: 8] = in_if.rec_byte;
              end
            end
          end
          if (in_if.last) begin
            rs_nxt    = in_if.read_status;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (rs_r != RS_OK) begin
          fail_status_nxt = (rs_r == RS_NOT_FOUND) ? STAT_NOT_FOUND : STAT_STORAGE_ERR;
          state_nxt       = ST_FAIL;
        end else if (good) begin
          emit_idx_nxt = '0;
          state_nxt    = ST_EMIT;
        end else begin
          fail_status_nxt = STAT_INVALID;
          state_nxt       = ST_FAIL;
        end
        byte_count_nxt = '0;
        ovf_nxt        = 1'b0;
        hdr_ok_nxt     = 1'b1;
        stored_crc_nxt = '0;
        crc_ctl.clear  = 1'b1;
      end
      ST_FAIL: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = 1'b0;
          out_status_nxt = fail_status_r;
          out_idx_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_COLLECT;
        end
      end
      ST_EMIT: begin
        // The buffer's read register serves as the data part of the output.
        if (out_free) begin
          ram_re         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = 1'b1;
          out_status_nxt = STAT_OK;
          out_idx_nxt    = emit_idx_r[4:0];
          out_last_nxt   = emit_last;
          emit_idx_nxt   = emit_idx_r + 6'd1;
          if (emit_last) begin
            emit_idx_nxt = '0;
            state_nxt    = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_COLLECT;
      exp_version_r  <= 16'd0;
      block_length_r <= 6'd1;
      byte_count_r   <= '0;
      ovf_r          <= 1'b0;
      hdr_ok_r       <= 1'b1;
      stored_crc_r   <= '0;
      emit_idx_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      ovf_r        <= ovf_nxt;
      hdr_ok_r     <= hdr_ok_nxt;
      stored_crc_r <= stored_crc_nxt;
      emit_idx_r   <= emit_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXPECTED_VERSION: exp_version_r  <= cfg_wdata;
          CFG_BLOCK_LENGTH:     block_length_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
    end
    rs_r          <= rs_nxt;
    fail_status_r <= fail_status_nxt;
    out_ok_r      <= out_ok_nxt;
    out_status_r  <= out_status_nxt;
    out_idx_r     <= out_idx_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.quality_valid = out_ok_r;
  assign out_if.dirty         = !out_ok_r;
  assign out_if.data_byte     = out_ok_r ? ram_rdata : 8'h00;
  assign out_if.data_index    = out_idx_r;
  assign out_if.last_out      = out_last_r;

  a_last_goes_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && in_if.last |=> state_r == ST_CHECK)
    else $error("Final byte transfer did not start the record check");

  a_emit_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> emit_idx_r < block_length_r)
    else $error("Emission index ran past the block length");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(byte_count_r) <= TOTAL)
    else $error("Byte count exceeded the record size");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_last_r && out_status_r != STAT_OK)
    else $error("Failure result without end marker or with status ok");

endmodule
